/* design/per_channel_gate_int8_requantize_assert.svh */
// assertion helpers for the gate requantize block
// both expect i_clk and i_rst_n in scope
`ifndef PER_CHANNEL_GATE_INT8_REQUANTIZE_ASSERT_SVH
`define PER_CHANNEL_GATE_INT8_REQUANTIZE_ASSERT_SVH

// same-cycle implication
`define PCG_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/pcg_pkg.sv */
`timescale 1ns / 1ps
package pcg_pkg;

    localparam int PCG_MAX_CHANNELS = 256;
    localparam int PCG_PLANE_BITS   = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam int MULT_W   = 31;
    localparam int SHIFT_W  = 6;
    localparam int CHCNT_W  = 9;
    localparam int PLANE_W  = 25;
    localparam int BATCH_W  = 16;
    localparam int MAG_W    = 15;
    localparam int PROD_W   = MAG_W + MULT_W;

    localparam logic [MULT_W-1:0]  MULT_RESET  = 31'd1073741824;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd30;

    // command field of an input word
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_PROCESS = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_MULT  = 3'd0,
        CFG_SCALE_SHIFT = 3'd1,
        CFG_CHAN_COUNT  = 3'd2,
        CFG_PLANE_SIZE  = 3'd3,
        CFG_BATCH_COUNT = 3'd4
    } t_cfg_index;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_SHIFT,
        S_SAT
    } t_state;

    typedef struct packed {
        logic accept_load;
        logic accept_proc;
        logic ld_mag;
        logic ld_prod;
        logic ld_shift;
        logic ld_out;
    } t_pcg_cmd;

    typedef struct packed {
        logic out_busy;
    } t_pcg_status;

endpackage

/* design/pcg_in_if.sv */
`timescale 1ns / 1ps
interface pcg_in_if;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic        [7:0] gate_channel;
    logic signed [7:0] gate_value;
    logic signed [7:0] sample;

    modport source (output valid, output cmd, output gate_channel, output gate_value,
                    output sample, input ready);
    modport sink   (input valid, input cmd, input gate_channel, input gate_value,
                    input sample, output ready);
endinterface

/* design/pcg_out_if.sv */
`timescale 1ns / 1ps
interface pcg_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] out_value;
    logic              last_of_tensor;

    modport source (output valid, output out_value, output last_of_tensor, input ready);
    modport sink   (input valid, input out_value, input last_of_tensor, output ready);
endinterface

/* design/per_channel_gate_int8_requantize.sv */
`timescale 1ns / 1ps
// flow: a sample word is accepted in idle and walked by the controller through gate read, gate
// product, scale product, shift and round/clamp; the last step waits while the previous result
// word is unclaimed, and no new word is taken until it is done; a load word keeps the block idle
// reset: synchronous, active low; config registers go to defaults, position counters to
// zero, output word dropped; the gate table is not cleared and holds garbage until loaded
`include "per_channel_gate_int8_requantize_assert.svh"
module per_channel_gate_int8_requantize
    import pcg_pkg::*;
#(
    parameter int MAX_CHANNELS = PCG_MAX_CHANNELS,
    parameter int PLANE_BITS   = PCG_PLANE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    pcg_in_if.sink                i_sample_ch,
    pcg_out_if.source             o_result_ch
);

    t_pcg_cmd    w_cmd;
    t_pcg_status w_status;

    pcg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample_ch.valid),
        .i_in_cmd   (i_sample_ch.cmd),
        .o_in_ready (i_sample_ch.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pcg_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .PLANE_BITS   (PLANE_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_gate_channel   (i_sample_ch.gate_channel),
        .i_gate_value     (i_sample_ch.gate_value),
        .i_sample         (i_sample_ch.sample),
        .i_out_ready      (o_result_ch.ready),
        .o_out_valid      (o_result_ch.valid),
        .o_out_value      (o_result_ch.out_value),
        .o_last_of_tensor (o_result_ch.last_of_tensor),
        .i_cmd            (w_cmd),
        .o_status         (w_status)
    );

    `PCG_ASSERT_NEXT(a_proc_starts_mul, w_cmd.accept_proc, w_cmd.ld_mag, "sample did not enter the product stage")
    `PCG_ASSERT_IMP(a_out_not_overwritten, w_cmd.ld_out, !w_status.out_busy, "output word overwritten while unclaimed")
    `PCG_ASSERT_IMP(a_accept_on_handshake, w_cmd.accept_load || w_cmd.accept_proc, i_sample_ch.valid && i_sample_ch.ready, "word taken without handshake")
    `PCG_ASSERT_IMP(a_one_step_at_once, 1'b1, $onehot0(w_cmd), "more than one datapath step in a cycle")

endmodule

/* design/pcg_ctrl.sv */
`timescale 1ns / 1ps
module pcg_ctrl
    import pcg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_cmd,
    output logic        o_in_ready,
    input  t_pcg_status i_status,
    output t_pcg_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_cmd == CMD_PROCESS) begin
                        o_cmd.accept_proc = 1'b1;
                        n_state           = S_MUL;
                    end else begin
                        o_cmd.accept_load = 1'b1;
                    end
                end
            end
            S_MUL: begin
                o_cmd.ld_mag = 1'b1;
                n_state      = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.ld_prod = 1'b1;
                n_state       = S_SHIFT;
            end
            S_SHIFT: begin
                o_cmd.ld_shift = 1'b1;
                n_state        = S_SAT;
            end
            S_SAT: begin
                // wait here while the previous word is still unclaimed
                if (!i_status.out_busy) begin
                    o_cmd.ld_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* design/pcg_datapath.sv */
`timescale 1ns / 1ps
module pcg_datapath
    import pcg_pkg::*;
#(
    parameter int MAX_CHANNELS = PCG_MAX_CHANNELS,
    parameter int PLANE_BITS   = PCG_PLANE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic            [7:0] i_gate_channel,
    input  logic signed     [7:0] i_gate_value,
    input  logic signed     [7:0] i_sample,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic signed     [7:0] o_out_value,
    output logic                  o_last_of_tensor,
    input  t_pcg_cmd              i_cmd,
    output t_pcg_status           o_status
);

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CCW   = (CH_W + 1 > CHCNT_W) ? CH_W + 1 : CHCNT_W;
    localparam int PCW   = (PLANE_BITS + 1 > PLANE_W) ? PLANE_BITS + 1 : PLANE_W;
    localparam int BCW   = BATCH_W + 1;

    // configuration
    logic [MULT_W-1:0]  r_scale_mult;
    logic [SHIFT_W-1:0] r_scale_shift;
    logic [CHCNT_W-1:0] r_chan_count;
    logic [PLANE_W-1:0] r_plane_size;
    logic [BATCH_W-1:0] r_batch_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_mult  <= MULT_RESET;
            r_scale_shift <= SHIFT_RESET;
            r_chan_count  <= CHCNT_W'(1);
            r_plane_size  <= PLANE_W'(1);
            r_batch_count <= BATCH_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCALE_MULT:  r_scale_mult  <= i_cfg_data[MULT_W-1:0];
                CFG_SCALE_SHIFT: r_scale_shift <= i_cfg_data[SHIFT_W-1:0];
                CFG_CHAN_COUNT:  r_chan_count  <= i_cfg_data[CHCNT_W-1:0];
                CFG_PLANE_SIZE:  r_plane_size  <= i_cfg_data[PLANE_W-1:0];
                CFG_BATCH_COUNT: r_batch_count <= i_cfg_data[BATCH_W-1:0];
                default: ;
            endcase
        end
    end

    // gate table
    logic signed [7:0] r_gate_mem [MAX_CHANNELS];
    logic signed [7:0] r_gate;
    logic [CH_W-1:0]   r_chan_pos;
    logic              w_gate_in_range;

    assign w_gate_in_range = {24'd0, i_gate_channel} < 32'(MAX_CHANNELS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_load && w_gate_in_range) begin
            r_gate_mem[CH_W'(i_gate_channel)] <= i_gate_value;
        end
        if (i_cmd.accept_proc) begin
            r_gate <= r_gate_mem[r_chan_pos];
        end
    end

    // position counters
    logic [PLANE_BITS-1:0] r_plane_pos;
    logic [BATCH_W-1:0]    r_batch_pos;
    logic [PCW-1:0]        w_plane_eff;
    logic [PCW-1:0]        w_plane_inc;
    logic [CCW-1:0]        w_chan_eff;
    logic [CCW-1:0]        w_chan_inc;
    logic [BCW-1:0]        w_batch_eff;
    logic [BCW-1:0]        w_batch_inc;
    logic                  w_plane_wrap;
    logic                  w_chan_wrap;
    logic                  w_batch_wrap;

    always_comb begin
        // zero counts act as one, oversized plane and channel counts are capped
        if (r_plane_size == '0) begin
            w_plane_eff = PCW'(1);
        end else if (PCW'(r_plane_size) > (PCW'(1) << PLANE_BITS)) begin
            w_plane_eff = PCW'(1) << PLANE_BITS;
        end else begin
            w_plane_eff = PCW'(r_plane_size);
        end
        if (r_chan_count == '0) begin
            w_chan_eff = CCW'(1);
        end else if (CCW'(r_chan_count) > CCW'(MAX_CHANNELS)) begin
            w_chan_eff = CCW'(MAX_CHANNELS);
        end else begin
            w_chan_eff = CCW'(r_chan_count);
        end
        w_batch_eff  = (r_batch_count == '0) ? BCW'(1) : {1'b0, r_batch_count};
        w_plane_inc  = PCW'(r_plane_pos) + PCW'(1);
        w_chan_inc   = CCW'(r_chan_pos) + CCW'(1);
        w_batch_inc  = {1'b0, r_batch_pos} + BCW'(1);
        w_plane_wrap = w_plane_inc >= w_plane_eff;
        w_chan_wrap  = w_chan_inc >= w_chan_eff;
        w_batch_wrap = w_batch_inc >= w_batch_eff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_pos <= '0;
            r_chan_pos  <= '0;
            r_batch_pos <= '0;
        end else if (i_cmd.accept_load) begin
            r_plane_pos <= '0;
            r_chan_pos  <= '0;
            r_batch_pos <= '0;
        end else if (i_cmd.accept_proc) begin
            if (w_plane_wrap) begin
                r_plane_pos <= '0;
                if (w_chan_wrap) begin
                    r_chan_pos <= '0;
                    r_batch_pos <= w_batch_wrap ? '0 : w_batch_inc[BATCH_W-1:0];
                end else begin
                    r_chan_pos <= w_chan_inc[CH_W-1:0];
                end
            end else begin
                r_plane_pos <= w_plane_inc[PLANE_BITS-1:0];
            end
        end
    end

    // arithmetic stages
    logic signed [7:0]   r_sample;
    logic                r_last;
    logic [MAG_W-1:0]    r_mag;
    logic                r_neg;
    logic [PROD_W-1:0]   r_prod;
    logic [PROD_W-1:0]   r_q;
    logic                r_rnd;
    logic                r_stk;
    logic signed [15:0]  w_gate_prod;
    logic signed [15:0]  w_gate_abs;
    logic [SHIFT_W-1:0]  w_sm1;
    logic [PROD_W-1:0]   w_round_src;
    logic [PROD_W-1:0]   w_stk_mask;
    logic [PROD_W-1:0]   w_q_rounded;
    logic signed [7:0]   w_sat;

    assign w_gate_prod = r_sample * r_gate;
    assign w_gate_abs  = w_gate_prod[15] ? -w_gate_prod : w_gate_prod;
    assign w_sm1       = r_scale_shift - SHIFT_W'(1);
    assign w_round_src = r_prod >> w_sm1;
    assign w_stk_mask  = ~({PROD_W{1'b1}} << w_sm1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_proc) begin
            r_sample <= i_sample;
            r_last   <= w_plane_wrap && w_chan_wrap && w_batch_wrap;
        end
        if (i_cmd.ld_mag) begin
            r_mag <= w_gate_abs[MAG_W-1:0];
            r_neg <= w_gate_prod[15];
        end
        if (i_cmd.ld_prod) begin
            r_prod <= PROD_W'(r_mag) * PROD_W'(r_scale_mult);
        end
        if (i_cmd.ld_shift) begin
            r_q <= r_prod >> r_scale_shift;
            if (r_scale_shift == '0) begin
                r_rnd <= 1'b0;
                r_stk <= 1'b0;
            end else begin
                r_rnd <= w_round_src[0];
                r_stk <= |(r_prod & w_stk_mask);
            end
        end
    end

    // round half to even, then clamp to int8
    always_comb begin
        w_q_rounded = r_q + PROD_W'(r_rnd && (r_stk || r_q[0]));
        if (r_neg) begin
            w_sat = (w_q_rounded > PROD_W'(128)) ? 8'sh80 : -$signed(w_q_rounded[7:0]);
        end else begin
            w_sat = (w_q_rounded > PROD_W'(127)) ? 8'sh7f : $signed(w_q_rounded[7:0]);
        end
    end

    // output register
    logic              r_out_valid;
    logic signed [7:0] r_out_value;
    logic              r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_out) begin
            r_out_value <= w_sat;
            r_out_last  <= r_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_value       = r_out_value;
    assign o_last_of_tensor  = r_out_last;
    assign o_status.out_busy = r_out_valid && !i_out_ready;

endmodule

/* tb/per_channel_gate_int8_requantize_tb.sv */
`timescale 1ns / 1ps
module per_channel_gate_int8_requantize_tb;
    import pcg_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned RANDOM_WORDS  = 100;
    localparam int unsigned DRAIN_CYCLES  = 12;
    localparam int unsigned PLANE_CAP     = 1 << PCG_PLANE_BITS;
    localparam logic [MULT_W-1:0]  MULT_MAX    = {MULT_W{1'b1}};
    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 6'd62;
    localparam logic [CHCNT_W-1:0] CHCNT_MAX   = {CHCNT_W{1'b1}};
    localparam logic [PLANE_W-1:0] PLANE_MAX   = {PLANE_W{1'b1}};
    localparam logic [BATCH_W-1:0] BATCH_MAX   = {BATCH_W{1'b1}};
    localparam logic signed [7:0]  SAT_MAX     = 8'sd127;
    localparam logic signed [7:0]  SAT_MIN     = -8'sd128;

    typedef struct packed {
        logic signed [7:0] value;
        logic              last;
    } t_result_word;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pcg_in_if  in_ch ();
    pcg_out_if out_ch ();

    per_channel_gate_int8_requantize dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_sample_ch (in_ch),
        .o_result_ch (out_ch)
    );

    // predictor state
    logic [MULT_W-1:0]  cur_mult;
    logic [SHIFT_W-1:0] cur_shift;
    logic [CHCNT_W-1:0] cur_chans;
    logic [PLANE_W-1:0] cur_plane;
    logic [BATCH_W-1:0] cur_batches;
    logic signed [7:0]  gate_mem [PCG_MAX_CHANNELS];
    bit                 gate_set [PCG_MAX_CHANNELS];
    int unsigned        plane_idx;
    int unsigned        chan_idx;
    int unsigned        batch_idx;

    t_result_word       pending_q [$];
    int unsigned        mismatches;
    int unsigned        words_sent;
    int unsigned        cycle_count;
    bit                 no_idle;

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned eff_planes();
        if (cur_plane == 0)
            return 1;
        return (cur_plane > PLANE_CAP) ? PLANE_CAP : int'(cur_plane);
    endfunction

    function automatic int unsigned eff_chans();
        if (cur_chans == 0)
            return 1;
        return (cur_chans > PCG_MAX_CHANNELS) ? PCG_MAX_CHANNELS : int'(cur_chans);
    endfunction

    function automatic int unsigned eff_batches();
        return (cur_batches == 0) ? 1 : int'(cur_batches);
    endfunction

    function automatic void apply_gate_load(logic [7:0] ch, logic signed [7:0] gv);
        gate_mem[ch] = gv;
        gate_set[ch] = 1'b1;
        plane_idx    = 0;
        chan_idx     = 0;
        batch_idx    = 0;
    endfunction

    // gate product, fixed-point scale, round half to even, clamp, then step the counters
    function automatic t_result_word requantize_next(logic signed [7:0] smp);
        int unsigned       pc;
        int unsigned       cc;
        int unsigned       bc;
        logic signed [15:0] prod;
        logic [15:0]       mag16;
        logic [63:0]       mag;
        logic [63:0]       q;
        logic [63:0]       rem;
        logic [63:0]       half;
        logic              neg;
        logic              plane_end;
        logic              chan_end;
        logic              batch_end;
        t_result_word      r;
        pc    = eff_planes();
        cc    = eff_chans();
        bc    = eff_batches();
        prod  = smp * gate_mem[chan_idx % PCG_MAX_CHANNELS];
        neg   = prod[15];
        mag16 = neg ? 16'(-prod) : 16'(prod);
        mag   = 64'(mag16) * 64'(cur_mult);
        q     = mag;
        if (cur_shift != 0) begin
            q    = mag >> cur_shift;
            rem  = mag & ((64'd1 << cur_shift) - 64'd1);
            half = 64'd1 << (cur_shift - 1);
            if (rem > half || (rem == half && q[0]))
                q = q + 64'd1;
        end
        if (neg)
            r.value = (q > 64'd128) ? SAT_MIN : 8'(8'd0 - q[7:0]);
        else
            r.value = (q > 64'd127) ? SAT_MAX : 8'(q[7:0]);
        plane_end = (plane_idx + 1 >= pc);
        chan_end  = (chan_idx + 1 >= cc);
        batch_end = (batch_idx + 1 >= bc);
        r.last    = plane_end && chan_end && batch_end;
        if (plane_end) begin
            plane_idx = 0;
            if (chan_end) begin
                chan_idx  = 0;
                batch_idx = batch_end ? 0 : batch_idx + 1;
            end else begin
                chan_idx = chan_idx + 1;
            end
        end else begin
            plane_idx = plane_idx + 1;
        end
        return r;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(logic op, logic [7:0] ch, logic signed [7:0] gv,
                             logic signed [7:0] smp);
        int unsigned gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.cmd          <= op;
        in_ch.gate_channel <= ch;
        in_ch.gate_value   <= gv;
        in_ch.sample       <= smp;
        do @(posedge clk); while (!in_ch.ready);
        if (op == CMD_PROCESS)
            pending_q.push_back(requantize_next(smp));
        else
            apply_gate_load(ch, gv);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic load_gate(logic [7:0] ch, logic signed [7:0] gv);
        send_word(CMD_LOAD, ch, gv, 8'($urandom));
    endtask

    task automatic push_sample(logic signed [7:0] smp);
        send_word(CMD_PROCESS, 8'($urandom), 8'($urandom), smp);
    endtask

    // drop valid and wait for every outstanding result, plus the pipeline depth
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_regs(logic [MULT_W-1:0] mult, logic [SHIFT_W-1:0] shift,
                              logic [CHCNT_W-1:0] chans, logic [PLANE_W-1:0] plane,
                              logic [BATCH_W-1:0] batches);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SCALE_MULT;
        cfg_data  <= CFG_DATA_W'(mult);
        @(negedge clk);
        cfg_index <= CFG_SCALE_SHIFT;
        cfg_data  <= CFG_DATA_W'(shift);
        @(negedge clk);
        cfg_index <= CFG_CHAN_COUNT;
        cfg_data  <= CFG_DATA_W'(chans);
        @(negedge clk);
        cfg_index <= CFG_PLANE_SIZE;
        cfg_data  <= CFG_DATA_W'(plane);
        @(negedge clk);
        cfg_index <= CFG_BATCH_COUNT;
        cfg_data  <= CFG_DATA_W'(batches);
        @(negedge clk);
        cfg_we      <= 1'b0;
        cur_mult    = mult;
        cur_shift   = shift;
        cur_chans   = chans;
        cur_plane   = plane;
        cur_batches = batches;
    endtask

    // every channel in use must hold a gate; at least one load also rewinds the counters
    task automatic prime_gates();
        int unsigned cc;
        cc = eff_chans();
        load_gate(8'($urandom), 8'($urandom));
        for (int unsigned ch = 0; ch < cc; ch++) begin
            if (!gate_set[ch] || $urandom_range(0, 3) == 0)
                load_gate(8'(ch), 8'($urandom));
        end
    endtask

    task automatic test_unity_scale_extremes();
        load_gate(8'd0, SAT_MAX);
        push_sample(SAT_MIN);
        push_sample(SAT_MAX);
        push_sample(8'sd0);
        push_sample(8'sd1);
        load_gate(8'd255, 8'sd0);
        load_gate(8'd0, SAT_MIN);
        push_sample(SAT_MIN);
        push_sample(SAT_MAX);
        push_sample(-8'sd1);
    endtask

    task automatic test_rounding_ties();
        // product over two: ties go to the even neighbour
        write_regs(31'd1, 6'd1, 9'd1, 25'd1, 16'd1);
        load_gate(8'd0, 8'sd1);
        push_sample(8'sd1);
        push_sample(8'sd3);
        push_sample(8'sd5);
        push_sample(-8'sd1);
        push_sample(-8'sd3);
        push_sample(-8'sd5);
        // no fraction bits, no rounding
        write_regs(31'd1, 6'd0, 9'd1, 25'd1, 16'd1);
        load_gate(8'd0, 8'sd1);
        push_sample(-8'sd7);
        push_sample(8'sd100);
    endtask

    task automatic test_scale_extremes();
        write_regs(MULT_MAX, SHIFT_MAX, 9'd1, 25'd1, 16'd1);
        load_gate(8'd0, SAT_MIN);
        push_sample(SAT_MIN);
        write_regs(MULT_MAX, 6'd0, 9'd1, 25'd1, 16'd1);
        load_gate(8'd0, -8'sd1);
        push_sample(8'sd1);
        push_sample(-8'sd1);
        write_regs('0, SHIFT_RESET, 9'd1, 25'd1, 16'd1);
        load_gate(8'd0, SAT_MAX);
        push_sample(SAT_MIN);
    endtask

    task automatic test_counter_layout();
        // zero counts behave as one: every word ends the tensor
        write_regs(MULT_RESET, SHIFT_RESET, '0, '0, '0);
        load_gate(8'd0, 8'sd3);
        push_sample(8'sd5);
        push_sample(-8'sd9);
        write_regs(MULT_RESET, SHIFT_RESET, 9'd2, 25'd2, 16'd1);
        load_gate(8'd0, 8'sd2);
        load_gate(8'd1, -8'sd3);
        push_sample(8'sd10);
        push_sample(8'sd11);
        // a load in mid tensor rewinds to the first element
        load_gate(8'd1, 8'sd4);
        repeat (5) push_sample(8'($urandom));
    endtask

    task automatic test_oversized_counts();
        write_regs(MULT_RESET, SHIFT_RESET, CHCNT_MAX, PLANE_MAX, BATCH_MAX);
        load_gate(8'd0, -8'sd5);
        repeat (3) push_sample(8'($urandom));
    endtask

    task automatic test_full_channel_table();
        write_regs(31'd1 << 29, SHIFT_RESET, 9'd300, 25'd1, 16'd1);
        for (int unsigned ch = 0; ch < PCG_MAX_CHANNELS; ch++)
            load_gate(8'(ch), 8'($urandom));
        repeat (PCG_MAX_CHANNELS + 2) push_sample(8'($urandom));
    endtask

    task automatic pick_random_setting();
        logic [MULT_W-1:0]  m;
        logic [SHIFT_W-1:0] s;
        logic [CHCNT_W-1:0] c;
        logic [PLANE_W-1:0] p;
        logic [BATCH_W-1:0] b;
        longint unsigned    lo;
        longint unsigned    hi;
        if ($urandom_range(0, 9) == 0) begin
            m = MULT_W'($urandom);
            s = 6'($urandom_range(0, 62));
        end else begin
            // keep the overall scale near one so outputs spread over the int8 range
            s  = 6'($urandom_range(0, 34));
            lo = (s >= 8) ? (64'd1 << (s - 8)) : 64'd1;
            hi = 64'd1 << (s + 1);
            if (hi > 64'(MULT_MAX))
                hi = 64'(MULT_MAX);
            m = MULT_W'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
        end
        case ($urandom_range(0, 19))
            0:       p = '0;
            1:       p = PLANE_MAX;
            default: p = 25'($urandom_range(1, 5));
        endcase
        case ($urandom_range(0, 19))
            0:       c = '0;
            1:       c = 9'($urandom_range(256, 511));
            default: c = 9'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 19))
            0:       b = '0;
            1:       b = BATCH_MAX;
            default: b = 16'($urandom_range(1, 3));
        endcase
        write_regs(m, s, c, p, b);
    endtask

    task automatic test_random_streams();
        int unsigned     start;
        int unsigned     kind;
        int unsigned     count;
        longint unsigned words_per_tensor;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            if ($urandom_range(0, 6) == 0)
                pick_random_setting();
            no_idle = ($urandom_range(0, 5) == 0);
            kind    = $urandom_range(0, 9);
            prime_gates();
            words_per_tensor = longint'(eff_planes()) * eff_chans() * eff_batches();
            if (words_per_tensor > 200) begin
                count = $urandom_range(1, 40);
            end else if (kind <= 5) begin
                // whole tensor, sometimes running on into the next one
                count = int'(words_per_tensor);
                if ($urandom_range(0, 2) == 0)
                    count += $urandom_range(1, int'(words_per_tensor));
            end else if (kind <= 7) begin
                count = $urandom_range(1, int'(words_per_tensor));
            end else begin
                count = $urandom_range(4, 20);
            end
            for (int unsigned i = 0; i < count && words_sent - start < RANDOM_WORDS; i++) begin
                if (kind > 7 && $urandom_range(0, 3) == 0)
                    load_gate(8'($urandom), 8'($urandom));
                else
                    push_sample(8'($urandom));
            end
            if ($urandom_range(0, 7) == 0)
                settle();
        end
        no_idle = 1'b0;
    endtask

    // result side back-pressure
    initial begin
        int unsigned hold;
        out_ch.ready = 1'b0;
        hold = 0;
        forever begin
            @(negedge clk);
            if (no_idle) begin
                out_ch.ready <= 1'b1;
                hold = 0;
            end else if (hold > 0) begin
                hold--;
            end else if ($urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                hold = pick_gap();
            end else begin
                out_ch.ready <= 1'b1;
                hold = $urandom_range(0, 6);
            end
        end
    end

    always @(posedge clk) begin
        t_result_word exp_word;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result word: value %0d last %0b",
                             out_ch.out_value, out_ch.last_of_tensor);
                mismatches++;
            end else begin
                exp_word = pending_q.pop_front();
                if (out_ch.out_value !== exp_word.value
                        || out_ch.last_of_tensor !== exp_word.last) begin
                    if (mismatches < 10)
                        $display("mismatch: expected value %0d last %0b, got value %0d last %0b",
                                 exp_word.value, exp_word.last,
                                 out_ch.out_value, out_ch.last_of_tensor);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_SCALE_MULT;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.cmd          = CMD_LOAD;
        in_ch.gate_channel = '0;
        in_ch.gate_value   = '0;
        in_ch.sample       = '0;
        cur_mult           = MULT_RESET;
        cur_shift          = SHIFT_RESET;
        cur_chans          = 9'd1;
        cur_plane          = 25'd1;
        cur_batches        = 16'd1;
        plane_idx          = 0;
        chan_idx           = 0;
        batch_idx          = 0;
        words_sent         = 0;
        no_idle            = 1'b0;
        foreach (gate_set[i])
            gate_set[i] = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_unity_scale_extremes();
        test_rounding_ties();
        test_scale_extremes();
        test_counter_layout();
        test_oversized_counts();
        test_full_channel_table();
        test_random_streams();

        in_ch.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* per_channel_gate_int8_requantize.f */
+incdir+design
design/pcg_pkg.sv
design/pcg_in_if.sv
design/pcg_out_if.sv
design/pcg_ctrl.sv
design/pcg_datapath.sv
design/per_channel_gate_int8_requantize.sv
tb/per_channel_gate_int8_requantize_tb.sv
